// File: hw/rtl/sdtq_pkg.sv
// shared types and constants for the sorted deadline timer queue
// no dependencies; imported by every module of the block
package sdtq_pkg;

    // default number of alarm slots
    localparam int DEFAULT_QUEUE_DEPTH = 16;

    // field widths
    localparam int TIME_W  = 32;
    localparam int DELAY_W = 16;
    localparam int TAG_W   = 8;
    localparam int KIND_W  = 2;

    // command codes carried in the input tuser
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_TICK   = 1'b1;

    // result kinds carried in the output tuser
    localparam logic [KIND_W-1:0] KIND_ACCEPTED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REJECTED = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EXPIRED  = 2'd2;

    // one stored alarm
    typedef struct packed {
        logic [TIME_W-1:0]  deadline;
        logic [TAG_W-1:0]   tag;
        logic [DELAY_W-1:0] delay;
    } t_entry;

    // operand selection for the shared adder and comparator
    typedef struct packed {
        logic [TIME_W-1:0] add_a;
        logic [TIME_W-1:0] add_b;
        logic [TIME_W-1:0] cmp_a;
        logic [TIME_W-1:0] cmp_b;
    } t_alu_req;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_IRD,
        ST_ICMP,
        ST_TRD,
        ST_TCMP,
        ST_FIN
    } t_state;

endpackage

// File: hw/rtl/sdtq_mem.sv
// alarm store: one write port, one read port with registered read data
// depends on sdtq_pkg for the entry type
module sdtq_mem
    import sdtq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH,
    parameter int AW          = $clog2(QUEUE_DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_entry        i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_entry        o_rdata
);

    t_entry r_mem [QUEUE_DEPTH];
    t_entry r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/sdtq_alu.sv
// shared time unit: one 32-bit adder and one unsigned less-than compare
// depends on sdtq_pkg for the request struct
module sdtq_alu
    import sdtq_pkg::*;
(
    input  t_alu_req          i_req,
    output logic [TIME_W-1:0] o_sum,
    output logic              o_lt
);

    // wrapping add for deadlines and time advance
    assign o_sum = i_req.add_a + i_req.add_b;

    // unsigned ordering of deadlines and time
    assign o_lt = (i_req.cmp_a < i_req.cmp_b);

endmodule

// File: hw/rtl/sorted_deadline_timer_queue_top.sv
// top level of the sorted deadline timer queue: sequencer and output register
// depends on sdtq_pkg, sdtq_mem and sdtq_alu
//
// Commands enter on the slave stream: tuser is the command (0 insert,
// 1 one-second tick), tdata the delay in seconds and the tag. Results leave
// on the master stream: tuser is the kind, tdata the tag and the original
// delay, tlast marks the final result caused by a command.
// An insert gives exactly one result (accepted, or rejected when all
// QUEUE_DEPTH slots hold alarms). A tick advances the time by one and gives
// one result per alarm now due, in deadline order, or none at all.
// Entries live in a circular store ordered from a head pointer. An insert
// walks from the tail toward the head, moving each later-or-equal entry up
// one slot through a read state and a compare-and-write state, as set by the
// single store read port and the shared comparator; a compare that finds an
// earlier entry, or reaching the head, places the new one. A tick reads and
// compares the head entry, popping each due alarm, until one is not due or
// the queue is empty. tready is low while a command is in progress.
// A finished result waits in the output register while the receiver stalls,
// and the sequencer halts until it is taken.
// Reset empties the queue and clears time to zero; no clearing pass.
module sorted_deadline_timer_queue_top
    import sdtq_pkg::*;
#(
    parameter int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // slave command stream
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [23:0] i_s_axis_tdata,   // [15:0] delay_seconds, [23:16] tag
    input  logic        i_s_axis_tuser,   // [0] cmd
    // master result stream
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [23:0] o_m_axis_tdata,   // [7:0] fired_tag, [23:8] fired_delay
    output logic [1:0]  o_m_axis_tuser,   // [1:0] kind
    output logic        o_m_axis_tlast    // last
);

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int OW = $clog2(QUEUE_DEPTH + 1);
    localparam int SW = AW + 1;
    localparam logic [OW-1:0] FULL_CNT  = OW'(QUEUE_DEPTH);
    localparam logic [SW-1:0] DEPTH_SUM = SW'(QUEUE_DEPTH);

    // state
    t_state              r_state, n_state;
    logic [TIME_W-1:0]   r_now, n_now;
    logic [OW-1:0]       r_occ, n_occ;
    logic [AW-1:0]       r_head, n_head;
    logic [OW-1:0]       r_k, n_k;
    logic [TIME_W-1:0]   r_dl, n_dl;
    logic [TAG_W-1:0]    r_tag, n_tag;
    logic [DELAY_W-1:0]  r_delay, n_delay;
    // alarm held back until it is known whether another one is due
    logic                r_pend, n_pend;
    t_entry              r_pend_ent, n_pend_ent;
    // final result of the command
    logic [KIND_W-1:0]   r_fin_kind, n_fin_kind;
    // output register
    logic                r_m_valid, n_m_valid;
    logic [KIND_W-1:0]   r_m_kind, n_m_kind;
    logic [TAG_W-1:0]    r_m_tag, n_m_tag;
    logic [DELAY_W-1:0]  r_m_delay, n_m_delay;
    logic                r_m_last, n_m_last;

    // store and shared unit hookup
    logic                mem_we, mem_re;
    logic [AW-1:0]       mem_waddr, mem_raddr;
    t_entry              mem_wdata, mem_rdata;
    t_alu_req            alu_req;
    logic [TIME_W-1:0]   alu_sum;
    logic                alu_lt;

    logic                out_free;
    logic                s_xfer;
    logic [SW-1:0]       sum_k, sum_km1, sum_h1;
    logic [AW-1:0]       addr_k, addr_km1, head_inc;
    logic [OW-1:0]       k_m1;

    sdtq_mem #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .AW          (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    sdtq_alu u_alu (
        .i_req (alu_req),
        .o_sum (alu_sum),
        .o_lt  (alu_lt)
    );

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_xfer          = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free        = !r_m_valid || i_m_axis_tready;

    // circular slot addresses relative to the head, one wrap at most
    assign k_m1     = r_k - OW'(1);
    assign sum_k    = SW'(r_head) + SW'(r_k[AW-1:0]);
    assign sum_km1  = SW'(r_head) + SW'(k_m1[AW-1:0]);
    assign sum_h1   = SW'(r_head) + SW'(1);
    assign addr_k   = (sum_k   >= DEPTH_SUM) ? AW'(sum_k   - DEPTH_SUM) : AW'(sum_k);
    assign addr_km1 = (sum_km1 >= DEPTH_SUM) ? AW'(sum_km1 - DEPTH_SUM) : AW'(sum_km1);
    assign head_inc = (sum_h1  >= DEPTH_SUM) ? AW'(sum_h1  - DEPTH_SUM) : AW'(sum_h1);

    // shared unit operands by state
    always_comb begin
        alu_req.add_a = r_now;
        alu_req.add_b = (i_s_axis_tuser == CMD_TICK) ? TIME_W'(1)
                                                     : TIME_W'(i_s_axis_tdata[15:0]);
        if (r_state == ST_TCMP) begin
            alu_req.cmp_a = r_now;
            alu_req.cmp_b = mem_rdata.deadline;
        end else begin
            alu_req.cmp_a = mem_rdata.deadline;
            alu_req.cmp_b = r_dl;
        end
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_now     <= '0;
            r_occ     <= '0;
            r_head    <= '0;
            r_pend    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_now     <= n_now;
            r_occ     <= n_occ;
            r_head    <= n_head;
            r_pend    <= n_pend;
            r_m_valid <= n_m_valid;
        end
    end

    // working and payload registers
    always_ff @(posedge i_clk) begin
        r_k        <= n_k;
        r_dl       <= n_dl;
        r_tag      <= n_tag;
        r_delay    <= n_delay;
        r_pend_ent <= n_pend_ent;
        r_fin_kind <= n_fin_kind;
        r_m_kind   <= n_m_kind;
        r_m_tag    <= n_m_tag;
        r_m_delay  <= n_m_delay;
        r_m_last   <= n_m_last;
    end

    // sequencer
    always_comb begin
        n_state    = r_state;
        n_now      = r_now;
        n_occ      = r_occ;
        n_head     = r_head;
        n_k        = r_k;
        n_dl       = r_dl;
        n_tag      = r_tag;
        n_delay    = r_delay;
        n_pend     = r_pend;
        n_pend_ent = r_pend_ent;
        n_fin_kind = r_fin_kind;
        n_m_valid  = r_m_valid && !i_m_axis_tready;
        n_m_kind   = r_m_kind;
        n_m_tag    = r_m_tag;
        n_m_delay  = r_m_delay;
        n_m_last   = r_m_last;
        mem_we     = 1'b0;
        mem_waddr  = addr_k;
        mem_wdata  = mem_rdata;
        mem_re     = 1'b0;
        mem_raddr  = addr_km1;

        case (r_state)
            // take a command
            ST_IDLE: begin
                if (s_xfer) begin
                    n_delay = i_s_axis_tdata[15:0];
                    n_tag   = i_s_axis_tdata[23:16];
                    n_pend  = 1'b0;
                    if (i_s_axis_tuser == CMD_TICK) begin
                        n_now   = alu_sum;
                        n_state = ST_TRD;
                    end else if (r_occ == FULL_CNT) begin
                        n_fin_kind = KIND_REJECTED;
                        n_state    = ST_FIN;
                    end else begin
                        n_dl       = alu_sum;
                        n_k        = r_occ;
                        n_fin_kind = KIND_ACCEPTED;
                        n_state    = ST_IRD;
                    end
                end
            end
            // insert: read the entry below the hole, or fill the hole at the head
            ST_IRD: begin
                if (r_k == '0) begin
                    mem_we          = 1'b1;
                    mem_wdata.deadline = r_dl;
                    mem_wdata.tag   = r_tag;
                    mem_wdata.delay = r_delay;
                    n_occ           = r_occ + OW'(1);
                    n_state         = ST_FIN;
                end else begin
                    mem_re  = 1'b1;
                    n_state = ST_ICMP;
                end
            end
            // insert: move a later-or-equal entry up, or place the new one
            ST_ICMP: begin
                mem_we = 1'b1;
                if (!alu_lt) begin
                    n_k     = k_m1;
                    n_state = ST_IRD;
                end else begin
                    mem_wdata.deadline = r_dl;
                    mem_wdata.tag      = r_tag;
                    mem_wdata.delay    = r_delay;
                    n_occ              = r_occ + OW'(1);
                    n_state            = ST_FIN;
                end
            end
            // tick: read the head entry
            ST_TRD: begin
                mem_raddr = r_head;
                if (r_occ == '0) begin
                    n_fin_kind = KIND_EXPIRED;
                    n_state    = r_pend ? ST_FIN : ST_IDLE;
                end else begin
                    mem_re  = 1'b1;
                    n_state = ST_TCMP;
                end
            end
            // tick: pop the head entry if due, release the held alarm
            ST_TCMP: begin
                if (alu_lt) begin
                    n_fin_kind = KIND_EXPIRED;
                    n_state    = r_pend ? ST_FIN : ST_IDLE;
                end else if (!r_pend || out_free) begin
                    if (r_pend) begin
                        n_m_valid = 1'b1;
                        n_m_kind  = KIND_EXPIRED;
                        n_m_tag   = r_pend_ent.tag;
                        n_m_delay = r_pend_ent.delay;
                        n_m_last  = 1'b0;
                    end
                    n_pend     = 1'b1;
                    n_pend_ent = mem_rdata;
                    n_head     = head_inc;
                    n_occ      = r_occ - OW'(1);
                    n_state    = ST_TRD;
                end
            end
            // final result of the command
            ST_FIN: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_kind  = r_fin_kind;
                    n_m_last  = 1'b1;
                    if (r_fin_kind == KIND_EXPIRED) begin
                        n_m_tag   = r_pend_ent.tag;
                        n_m_delay = r_pend_ent.delay;
                    end else begin
                        n_m_tag   = r_tag;
                        n_m_delay = r_delay;
                    end
                    n_pend  = 1'b0;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // master outputs
    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {r_m_delay, r_m_tag};
    assign o_m_axis_tuser  = r_m_kind;
    assign o_m_axis_tlast  = r_m_last;

endmodule

// File: bench/tb_sorted_deadline_timer_queue_top.sv
// self-checking testbench for the sorted deadline timer queue top level
// depends on sdtq_pkg and sorted_deadline_timer_queue_top; holds its own predictor
`timescale 1ns / 1ps

module tb_sorted_deadline_timer_queue_top;
    import sdtq_pkg::*;

    localparam int DEPTH          = DEFAULT_QUEUE_DEPTH;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 80;
    localparam int MAX_REPORTS    = 10;

    // one pending alarm as the predictor keeps it
    typedef struct {
        logic [TIME_W-1:0]  deadline;
        logic [TAG_W-1:0]   tag;
        logic [DELAY_W-1:0] delay;
    } t_alarm;

    // one result as it leaves the block
    typedef struct {
        logic [KIND_W-1:0]  kind;
        logic [TAG_W-1:0]   tag;
        logic [DELAY_W-1:0] delay;
        logic               last;
    } t_alarm_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        cmd_tvalid;
    logic        cmd_tready;
    logic [23:0] cmd_tdata;   // [15:0] delay_seconds, [23:16] tag
    logic        cmd_tuser;   // [0] cmd
    logic        res_tvalid;
    logic        res_tready;
    logic [23:0] res_tdata;   // [7:0] fired_tag, [23:8] fired_delay
    logic [1:0]  res_tuser;   // [1:0] kind
    logic        res_tlast;

    // predictor state
    logic [TIME_W-1:0] now_sec;
    t_alarm            pending_alarms[$];
    t_alarm_result     expected_results[$];

    bit src_idle_on;
    bit sink_idle_on;
    int mismatch_count;
    int insert_count;
    int tick_count;
    int expired_count;
    int rejected_count;

    sorted_deadline_timer_queue_top #(
        .QUEUE_DEPTH(DEPTH)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (cmd_tvalid),
        .o_s_axis_tready (cmd_tready),
        .i_s_axis_tdata  (cmd_tdata),
        .i_s_axis_tuser  (cmd_tuser),
        .o_m_axis_tvalid (res_tvalid),
        .i_m_axis_tready (res_tready),
        .o_m_axis_tdata  (res_tdata),
        .o_m_axis_tuser  (res_tuser),
        .o_m_axis_tlast  (res_tlast)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // idle length: mostly none, sometimes short, rarely long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // expected results of one accepted command; updates the predicted queue
    function automatic void predict_command(logic cmd, logic [DELAY_W-1:0] delay,
                                            logic [TAG_W-1:0] tag);
        t_alarm        entry;
        t_alarm_result res;
        int            pos;
        int            due;
        if (cmd == CMD_INSERT) begin
            insert_count++;
            res.tag   = tag;
            res.delay = delay;
            res.last  = 1'b1;
            if (pending_alarms.size() >= DEPTH) begin
                res.kind = KIND_REJECTED;
                rejected_count++;
            end else begin
                // new entry goes ahead of equal deadlines
                entry.deadline = now_sec + TIME_W'(delay);
                entry.tag      = tag;
                entry.delay    = delay;
                pos = 0;
                while (pos < pending_alarms.size() &&
                       pending_alarms[pos].deadline < entry.deadline)
                    pos++;
                pending_alarms.insert(pos, entry);
                res.kind = KIND_ACCEPTED;
            end
            expected_results.push_back(res);
        end else begin
            tick_count++;
            now_sec = now_sec + 1;
            due = 0;
            while (due < pending_alarms.size() && pending_alarms[due].deadline <= now_sec)
                due++;
            for (int i = 0; i < due; i++) begin
                res.kind  = KIND_EXPIRED;
                res.tag   = pending_alarms[0].tag;
                res.delay = pending_alarms[0].delay;
                res.last  = (i == due - 1);
                expected_results.push_back(res);
                pending_alarms.delete(0);
                expired_count++;
            end
        end
    endfunction

    // drive one command and wait for its transfer
    task automatic send_command(logic cmd, logic [DELAY_W-1:0] delay, logic [TAG_W-1:0] tag);
        int gap;
        gap = src_idle_on ? pick_gap() : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            cmd_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        cmd_tdata  = {tag, delay};
        cmd_tuser  = cmd;
        cmd_tvalid = 1'b1;
        do @(posedge i_clk); while (!cmd_tready);
        predict_command(cmd, delay, tag);
    endtask

    task automatic send_tick();
        logic [23:0] noise;
        noise = 24'($urandom());
        send_command(CMD_TICK, noise[15:0], noise[23:16]);
    endtask

    // result receiver with random stalls
    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        res_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (sink_idle_on && stall_left > 0) begin
                res_tready = 1'b0;
                stall_left--;
            end else begin
                res_tready = 1'b1;
                if (sink_idle_on && $urandom_range(0, 99) < 35)
                    stall_left = pick_gap();
            end
        end
    end

    // compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin : check_results
        t_alarm_result want;
        t_alarm_result got;
        if (i_rst_n && res_tvalid && res_tready) begin
            got.kind  = res_tuser;
            got.tag   = res_tdata[7:0];
            got.delay = res_tdata[23:8];
            got.last  = res_tlast;
            if (expected_results.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("[%0t] unexpected result kind=%0d tag=%02h delay=%04h last=%0b",
                             $realtime, got.kind, got.tag, got.delay, got.last);
            end else begin
                want = expected_results.pop_front();
                if (got.kind !== want.kind || got.tag !== want.tag ||
                    got.delay !== want.delay || got.last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"[%0t] mismatch: expected kind=%0d tag=%02h delay=%04h ",
                                  "last=%0b, got kind=%0d tag=%02h delay=%04h last=%0b"},
                                 $realtime, want.kind, want.tag, want.delay, want.last,
                                 got.kind, got.tag, got.delay, got.last);
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((cmd_tvalid && cmd_tready) || (res_tvalid && res_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("[%0t] watchdog: no transfer for %0d cycles, %0d results outstanding",
                 $realtime, WATCHDOG_LIMIT, expected_results.size());
        $display("Some tests failed");
        $finish;
    end

    // single alarms, zero delay, and a tick with nothing due
    task automatic test_basic_expiry();
        send_command(CMD_INSERT, 16'h0000, 8'h00);
        send_tick();
        send_tick();
        send_command(CMD_INSERT, 16'h0001, 8'hA5);
        send_tick();
    endtask

    // equal deadlines: the newest one fires first
    task automatic test_equal_deadlines();
        send_command(CMD_INSERT, 16'd2, 8'h11);
        send_command(CMD_INSERT, 16'd2, 8'h22);
        send_command(CMD_INSERT, 16'd1, 8'h33);
        send_command(CMD_INSERT, 16'd2, 8'h44);
        send_tick();
        send_tick();
    endtask

    // fill the queue, overflow it, then expire a large batch in one tick
    task automatic test_queue_full();
        int n;
        n = 0;
        send_command(CMD_INSERT, 16'hFFFF, 8'hFF);
        while (pending_alarms.size() < DEPTH) begin
            send_command(CMD_INSERT, 16'd3, 8'(8'h80 + n));
            n++;
        end
        send_command(CMD_INSERT, 16'hFFFF, 8'hFF);
        send_command(CMD_INSERT, 16'h0000, 8'h00);
        repeat (3) send_tick();
    endtask

    // random mix of inserts, overflow bursts and ticks
    task automatic test_random_traffic(int n_items);
        int sent;
        int r;
        int burst;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 8) begin
                burst = DEPTH + 2 - pending_alarms.size();
                repeat (burst) begin
                    if (pending_alarms.size() >= DEPTH)
                        send_command(CMD_INSERT, 16'($urandom()), 8'($urandom()));
                    else
                        send_command(CMD_INSERT, 16'($urandom_range(0, 12)), 8'($urandom()));
                    sent++;
                end
            end else if (r < 50) begin
                send_command(CMD_INSERT, 16'($urandom_range(0, 12)), 8'($urandom()));
                sent++;
            end else if (r < 52) begin
                send_command(CMD_INSERT, 16'($urandom()), 8'($urandom()));
                sent++;
            end else begin
                send_tick();
                sent++;
            end
        end
    endtask

    // main sequence
    initial begin
        i_rst_n        = 1'b0;
        cmd_tvalid     = 1'b0;
        cmd_tdata      = '0;
        cmd_tuser      = CMD_INSERT;
        now_sec        = '0;
        src_idle_on    = 1'b1;
        sink_idle_on   = 1'b1;
        mismatch_count = 0;
        insert_count   = 0;
        tick_count     = 0;
        expired_count  = 0;
        rejected_count = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_basic_expiry();
        test_equal_deadlines();
        test_queue_full();
        test_random_traffic(95);
        src_idle_on  = 1'b0;
        sink_idle_on = 1'b0;
        test_random_traffic(95);

        @(negedge i_clk);
        cmd_tvalid = 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("covered %0d inserts (%0d rejected as full) and %0d ticks, %0d alarms expired",
                 insert_count, rejected_count, tick_count, expired_count);
        $display("%0d mismatches, %0d alarms still pending", mismatch_count,
                 pending_alarms.size());
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
